>>> rtl/core/kmbx_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed slot mailbox: sizes, status codes and beat types.
// Depends on nothing; every other file of the block imports it.
package kmbx_pkg;

    // Storage geometry.
    localparam int SLOTS        = 16;
    localparam int KEY_BITS     = 8;
    localparam int PAYLOAD_BITS = 64;
    localparam int SLOT_IDX_W   = $clog2(SLOTS);

    // Field widths of the command and result beats.
    localparam int CMD_W       = 1;
    localparam int KEY_FIELD_W = 8;
    localparam int DATA_W      = 64;
    localparam int STATUS_W    = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_STORE    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef logic [SLOT_IDX_W-1:0]   t_slot_idx;
    typedef logic [KEY_BITS-1:0]     t_slot_key;
    typedef logic [PAYLOAD_BITS-1:0] t_slot_data;

    // Command beat.
    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [KEY_FIELD_W-1:0] key;
        logic [DATA_W-1:0]      entry_data;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [KEY_FIELD_W-1:0] found_key;
        logic [DATA_W-1:0]      found_data;
    } t_out_item;

    // Sequencer requests to the slot store.
    typedef struct packed {
        t_slot_idx  idx;
        logic       wr_en;
        logic       clr_en;
        logic       rd_en;
        t_slot_key  wr_key;
        t_slot_data wr_data;
    } t_slot_req;

    // Slot store view of the slot under the scan index.
    typedef struct packed {
        logic       valid;
        t_slot_key  key;
        t_slot_data rd_data;
    } t_slot_rsp;

endpackage

>>> rtl/core/keyed_slot_mailbox.sv
`timescale 1ns / 1ps
// Top level of the keyed slot mailbox.
// Depends on kmbx_pkg, kmbx_slots and kmbx_seq.
//
// A command beat (i_item) is taken at a clock edge where start is high and
// busy is low. A store command writes key and payload into the lowest free
// slot; a retrieve command frees the lowest valid slot holding the key and
// returns its key and payload. Each command yields one result beat on
// o_result, marked by o_done for exactly one cycle; the receiver cannot
// stall it.
// The sequencer checks one slot per cycle, using a single key compare for
// retrievals; a command examines between 1 and 16 slots, and a successful
// retrieval adds a payload memory read in the fetch state. The result
// appears in the cycle in which the block goes idle, and busy is already low
// in that cycle, so the next command may be taken alongside the strobe.
// Reset clears all valid flags and returns the sequencer to idle; slot keys
// and payloads are not cleared and are read only after being written.
module keyed_slot_mailbox (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  kmbx_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output kmbx_pkg::t_out_item o_result
);
    import kmbx_pkg::*;

    t_slot_req slot_req;
    t_slot_rsp slot_rsp;

    // Scan sequencer with the shared key compare.
    kmbx_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_req    (slot_req),
        .i_rsp    (slot_rsp)
    );

    // Slot storage.
    kmbx_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

endmodule

>>> rtl/core/kmbx_slots.sv
`timescale 1ns / 1ps
// Slot store: valid flags, key registers and the payload memory.
// Depends on kmbx_pkg.
module kmbx_slots (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kmbx_pkg::t_slot_req i_req,
    output kmbx_pkg::t_slot_rsp o_rsp
);
    import kmbx_pkg::*;

    logic [SLOTS-1:0] r_valid;
    t_slot_key        r_key [SLOTS];
    t_slot_data       r_mem [SLOTS];
    t_slot_data       r_rd_data;

    // Valid flags: set on store, cleared on retrieval, all clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.idx] <= 1'b1;
        end else if (i_req.clr_en) begin
            r_valid[i_req.idx] <= 1'b0;
        end
    end

    // Key registers, read at the scan index only.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_key[i_req.idx] <= i_req.wr_key;
        end
    end

    // Payload memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.idx];
        end
    end

    assign o_rsp.valid   = r_valid[i_req.idx];
    assign o_rsp.key     = r_key[i_req.idx];
    assign o_rsp.rd_data = r_rd_data;

endmodule

>>> rtl/core/kmbx_seq.sv
`timescale 1ns / 1ps
// Sequencer: walks the slots one per cycle, with a single key compare for retrievals.
// Depends on kmbx_pkg; drives the slot store in kmbx_slots.
module kmbx_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  kmbx_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output kmbx_pkg::t_out_item o_result,
    output kmbx_pkg::t_slot_req o_req,
    input  kmbx_pkg::t_slot_rsp i_rsp
);
    import kmbx_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;

    localparam t_slot_idx LAST_IDX = SLOT_IDX_W'(SLOTS - 1);

    logic [1:0]       r_state, n_state;
    t_slot_idx        r_idx, n_idx;
    logic [CMD_W-1:0] r_cmd;
    t_slot_key        r_key;
    t_slot_data       r_data;
    logic             r_done, n_done;
    t_out_item        r_result, n_result;

    logic accept;
    logic key_hit;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    // The one compare unit, reused for every slot of the scan.
    assign key_hit = i_rsp.valid && (i_rsp.key == r_key);

    // Latch the command beat when it is taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_item.command;
            r_key  <= i_item.key[KEY_BITS-1:0];
            r_data <= i_item.entry_data[PAYLOAD_BITS-1:0];
        end
    end

    // Scan control and slot store requests.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_result = r_result;

        o_req.idx     = r_idx;
        o_req.wr_en   = 1'b0;
        o_req.clr_en  = 1'b0;
        o_req.rd_en   = 1'b0;
        o_req.wr_key  = r_key;
        o_req.wr_data = r_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (r_cmd == CMD_STORE) begin
                    if (!i_rsp.valid) begin
                        o_req.wr_en = 1'b1;
                        n_done      = 1'b1;
                        n_result    = '{status: ST_STORED, found_key: '0, found_data: '0};
                        n_state     = S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_FULL, found_key: '0, found_data: '0};
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (key_hit) begin
                        o_req.clr_en = 1'b1;
                        o_req.rd_en  = 1'b1;
                        n_state      = S_FETCH;
                    end else if (r_idx == LAST_IDX) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_MISSING, found_key: '0, found_data: '0};
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                // Payload read data from the registered read port arrives in the cycle after the hit.
                n_done   = 1'b1;
                n_result = '{status:     ST_FOUND,
                             found_key:  KEY_FIELD_W'(r_key),
                             found_data: DATA_W'(i_rsp.rd_data)};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
        end
    end

    // Result register, valid under the strobe and held until the next result.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
